// ===== rtl/cti_pkg.sv =====
// Package for the cube to tetrahedra indexer: widths, register indexes,
// corner and tetrahedron tables, and the restoring divider step.
// No dependencies.
package cti_pkg;

   localparam int CELL_W    = 8;
   localparam int IDX_W     = 24;
   localparam int TET_W     = 3;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_TETS  = 6;
   localparam int DIV_STEPS = 8;
   localparam int DIV_STAGES = IDX_W / DIV_STEPS;

   localparam logic [CELL_W-1:0] MAX_CELLS   = 8'd255;
   localparam logic [CELL_W-1:0] CELLS_RESET = 8'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Z = 2'd2;

   localparam logic [TET_W-1:0] LAST_TET = 3'(NUM_TETS - 1);

   // corner offsets, bit 2 = x, bit 1 = y, bit 0 = z
   localparam logic [7:0][2:0] CORNER_TAB = {
      3'b110, 3'b001, 3'b010, 3'b011, 3'b101, 3'b111, 3'b100, 3'b000
   };

   typedef struct packed {
      logic [CELL_W-1:0] rem;
      logic [IDX_W-1:0]  dq;
      logic [CELL_W-1:0] side;
   } div_pipe_type;

   // corners of one tetrahedron, first vertex in the top bits
   function automatic logic [11:0] tet_corners(logic [TET_W-1:0] t);
      logic [11:0] c;
      case (t)
         3'd0:    c = {3'd3, 3'd5, 3'd1, 3'd2};
         3'd1:    c = {3'd3, 3'd5, 3'd4, 3'd0};
         3'd2:    c = {3'd3, 3'd5, 3'd2, 3'd4};
         3'd3:    c = {3'd4, 3'd3, 3'd0, 3'd6};
         3'd4:    c = {3'd3, 3'd5, 3'd0, 3'd1};
         3'd5:    c = {3'd1, 3'd5, 3'd7, 3'd2};
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [CELL_W-1:0] clamp_cells(logic [CELL_W-1:0] v);
      logic [CELL_W-1:0] r;
      r = (v > MAX_CELLS) ? MAX_CELLS : v;
      return r;
   endfunction

   // one restoring division step: shift in the next dividend bit
   function automatic div_pipe_type div_step(div_pipe_type s, logic [CELL_W-1:0] d);
      logic [CELL_W:0] trial;
      div_pipe_type    r;
      trial = {s.rem, s.dq[IDX_W-1]};
      r     = s;
      if (trial >= {1'b0, d}) begin
         r.rem = CELL_W'(trial - {1'b0, d});
         r.dq  = {s.dq[IDX_W-2:0], 1'b1};
      end else begin
         r.rem = trial[CELL_W-1:0];
         r.dq  = {s.dq[IDX_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== rtl/cti_div_stage.sv =====
// One register stage of the pipelined restoring divider (several steps).
// Depends on cti_pkg.
module cti_div_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  cti_pkg::div_pipe_type     in_data,
   input  logic [cti_pkg::CELL_W-1:0] divisor,
   output logic                      out_valid,
   output cti_pkg::div_pipe_type     out_data
);

   logic                  valid_ff;
   cti_pkg::div_pipe_type data_ff;
   cti_pkg::div_pipe_type data_in;

   always_comb begin
      data_in = in_data;
      for (int i = 0; i < cti_pkg::DIV_STEPS; i++) begin
         data_in = cti_pkg::div_step(data_in, divisor);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/cube_to_tetrahedra_indexer_unit.sv =====
// Cube to tetrahedra indexer, top level. Depends on cti_pkg, cti_div_stage.
// Throughput: the result emitter gives one tetrahedron a cycle, six for an
// in-range item and a single out-of-range answer for any other; a new item
// enters each cycle while the emitter has room. Results cannot be stalled by
// the receiver.
// Reset: synchronous; clears pipeline valid bits and sets all cell counts to 1.
module cube_to_tetrahedra_indexer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cti_pkg::IDX_W-1:0]     req_cube_index,
   output logic                          rsp_strobe,
   output logic [cti_pkg::TET_W-1:0]     rsp_tet_number,
   output logic [cti_pkg::IDX_W-1:0]     rsp_vertex_a,
   output logic [cti_pkg::IDX_W-1:0]     rsp_vertex_b,
   output logic [cti_pkg::IDX_W-1:0]     rsp_vertex_c,
   output logic [cti_pkg::IDX_W-1:0]     rsp_vertex_d,
   output logic                          rsp_out_of_range,
   output logic                          rsp_last_tet,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cti_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cti_pkg::CELL_W-1:0]    csr_data
);

   localparam int CW = cti_pkg::CELL_W;
   localparam int IW = cti_pkg::IDX_W;
   localparam int NS = 2 * cti_pkg::DIV_STAGES;

   // configuration
   logic [CW-1:0]   cx_ff, cy_ff, cz_ff;
   logic [CW:0]     cy_p1, cz_p1;
   logic [2*CW+1:0] sx_ff;

   assign csr_ready = 1'b1;
   assign cy_p1     = {1'b0, cy_ff} + (CW+1)'(1);
   assign cz_p1     = {1'b0, cz_ff} + (CW+1)'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= cti_pkg::CELLS_RESET;
         cy_ff <= cti_pkg::CELLS_RESET;
         cz_ff <= cti_pkg::CELLS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            cti_pkg::CSR_CELLS_X: cx_ff <= cti_pkg::clamp_cells(csr_data);
            cti_pkg::CSR_CELLS_Y: cy_ff <= cti_pkg::clamp_cells(csr_data);
            cti_pkg::CSR_CELLS_Z: cz_ff <= cti_pkg::clamp_cells(csr_data);
            default: ;
         endcase
      end
   end

   // x stride of the point grid
   always_ff @(posedge clock) begin
      sx_ff <= cy_p1 * cz_p1;
   end

   // pipeline control
   logic advance;
   logic a1_valid_ff;
   logic em_valid_ff;
   logic em_oor_ff;
   logic [cti_pkg::TET_W-1:0] em_cnt_ff;
   logic em_last;
   logic em_free;
   logic em_load;

   assign em_last = em_oor_ff || (em_cnt_ff == cti_pkg::LAST_TET);
   assign em_free = !em_valid_ff || em_last;
   assign em_load = a1_valid_ff && em_free;
   assign advance = !a1_valid_ff || em_free;
   assign busy    = !advance;

   // divider: z = idx mod cz, then y = (idx / cz) mod cy, x = idx / cz / cy
   logic                  st_valid_in  [NS];
   cti_pkg::div_pipe_type st_data_in   [NS];
   logic                  st_valid_out [NS];
   cti_pkg::div_pipe_type st_data_out  [NS];

   always_comb begin
      for (int i = 0; i < NS; i++) begin
         if (i == 0) begin
            st_valid_in[i] = start && !busy;
            st_data_in[i]  = '{rem: '0, dq: req_cube_index, side: '0};
         end else if (i == cti_pkg::DIV_STAGES) begin
            st_valid_in[i] = st_valid_out[i-1];
            st_data_in[i]  = '{rem: '0, dq: st_data_out[i-1].dq,
                               side: st_data_out[i-1].rem};
         end else begin
            st_valid_in[i] = st_valid_out[i-1];
            st_data_in[i]  = st_data_out[i-1];
         end
      end
   end

   for (genvar g = 0; g < NS; g++) begin : g_div
      cti_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (st_valid_in[g]),
         .in_data   (st_data_in[g]),
         .divisor   ((g < cti_pkg::DIV_STAGES) ? cz_ff : cy_ff),
         .out_valid (st_valid_out[g]),
         .out_data  (st_data_out[g])
      );
   end

   // range check and first multiply
   cti_pkg::div_pipe_type dv;
   logic          m1_oor_in;
   logic [2*CW:0] m1_t_in;
   logic [2:0]    m1_par_in;

   assign dv        = st_data_out[NS-1];
   assign m1_oor_in = (cx_ff == '0) || (cy_ff == '0) || (cz_ff == '0)
                      || (dv.dq >= IW'(cx_ff));
   assign m1_t_in   = (2*CW+1)'(dv.dq[CW-1:0] * cy_p1) + (2*CW+1)'(dv.rem);
   assign m1_par_in = {dv.dq[0], dv.rem[0], dv.side[0]};

   logic          m1_valid_ff, m1_oor_ff;
   logic [2*CW:0] m1_t_ff;
   logic [CW-1:0] m1_z_ff;
   logic [2:0]    m1_par_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= st_valid_out[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_oor_ff <= m1_oor_in;
         m1_t_ff   <= m1_t_in;
         m1_z_ff   <= dv.side;
         m1_par_ff <= m1_par_in;
      end
   end

   // base point index of the cube
   logic [IW-1:0] m2_base_in;
   assign m2_base_in = IW'((3*CW+2)'(m1_t_ff * cz_p1) + (3*CW+2)'(m1_z_ff));

   logic          m2_valid_ff, m2_oor_ff;
   logic [IW-1:0] m2_base_ff;
   logic [2:0]    m2_par_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m2_oor_ff  <= m1_oor_ff;
         m2_base_ff <= m2_base_in;
         m2_par_ff  <= m1_par_ff;
      end
   end

   // base for both x offsets
   logic [IW-1:0] a1_bx1_in;
   assign a1_bx1_in = m2_base_ff + IW'(sx_ff);

   logic          a1_oor_ff;
   logic [IW-1:0] a1_bx0_ff, a1_bx1_ff;
   logic [2:0]    a1_par_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_valid_ff <= 1'b0;
      end else if (advance) begin
         a1_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a1_oor_ff <= m2_oor_ff;
         a1_bx0_ff <= m2_base_ff;
         a1_bx1_ff <= a1_bx1_in;
         a1_par_ff <= m2_par_ff;
      end
   end

   // emitter: one tetrahedron a cycle
   logic                      em_valid_in;
   logic [cti_pkg::TET_W-1:0] em_cnt_in;
   logic [IW-1:0]             em_bx0_ff, em_bx1_ff;
   logic [2:0]                em_par_ff;

   always_comb begin
      em_valid_in = em_valid_ff;
      em_cnt_in   = em_cnt_ff;
      if (em_load) begin
         em_valid_in = 1'b1;
         em_cnt_in   = '0;
      end else if (em_valid_ff && em_last) begin
         em_valid_in = 1'b0;
      end else if (em_valid_ff) begin
         em_cnt_in = em_cnt_ff + cti_pkg::TET_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         em_cnt_ff   <= '0;
         em_oor_ff   <= 1'b0;
      end else begin
         em_valid_ff <= em_valid_in;
         em_cnt_ff   <= em_cnt_in;
         if (em_load) begin
            em_oor_ff <= a1_oor_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (em_load) begin
         em_bx0_ff <= a1_bx0_ff;
         em_bx1_ff <= a1_bx1_ff;
         em_par_ff <= a1_par_ff;
      end
   end

   // vertex indices of the current tetrahedron
   logic [11:0]   corners;
   logic [IW-1:0] vert_in [4];

   assign corners = cti_pkg::tet_corners(em_cnt_ff);

   always_comb begin
      logic [2:0] off;
      for (int k = 0; k < 4; k++) begin
         off        = cti_pkg::CORNER_TAB[corners[3*(3-k) +: 3]] ^ em_par_ff;
         vert_in[k] = (off[2] ? em_bx1_ff : em_bx0_ff)
                      + (off[1] ? IW'(cz_p1) : '0) + IW'(off[0]);
         if (em_oor_ff) begin
            vert_in[k] = '0;
         end
      end
   end

   // output register
   logic                      rsp_strobe_ff, rsp_oor_ff, rsp_last_ff;
   logic [cti_pkg::TET_W-1:0] rsp_tet_ff;
   logic [IW-1:0]             rsp_va_ff, rsp_vb_ff, rsp_vc_ff, rsp_vd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= em_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tet_ff  <= em_oor_ff ? '0 : em_cnt_ff;
      rsp_va_ff   <= vert_in[0];
      rsp_vb_ff   <= vert_in[1];
      rsp_vc_ff   <= vert_in[2];
      rsp_vd_ff   <= vert_in[3];
      rsp_oor_ff  <= em_oor_ff;
      rsp_last_ff <= em_last;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_tet_number   = rsp_tet_ff;
   assign rsp_vertex_a     = rsp_va_ff;
   assign rsp_vertex_b     = rsp_vb_ff;
   assign rsp_vertex_c     = rsp_vc_ff;
   assign rsp_vertex_d     = rsp_vd_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_last_tet     = rsp_last_ff;

endmodule

// ===== tb/tb_cube_to_tetrahedra_indexer_unit.sv =====
// Testbench for cube_to_tetrahedra_indexer_unit: predicts the six tetrahedra of each
// cube index (or the single out-of-range answer) and checks every result in order.
// Depends on cti_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_cube_to_tetrahedra_indexer_unit;

   localparam int LIMIT = 100000;
   localparam logic [cti_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // corner offsets, bit 2 = x, bit 1 = y, bit 0 = z
   localparam logic [0:7][2:0] CUBE_CORNER = {
      3'b000, 3'b100, 3'b111, 3'b101, 3'b011, 3'b010, 3'b001, 3'b110
   };
   localparam logic [0:5][0:3][2:0] TET_CORNER = {
      3'd3, 3'd5, 3'd1, 3'd2,
      3'd3, 3'd5, 3'd4, 3'd0,
      3'd3, 3'd5, 3'd2, 3'd4,
      3'd4, 3'd3, 3'd0, 3'd6,
      3'd3, 3'd5, 3'd0, 3'd1,
      3'd1, 3'd5, 3'd7, 3'd2
   };

   typedef struct packed {
      logic [cti_pkg::TET_W-1:0] tet_number;
      logic [cti_pkg::IDX_W-1:0] vertex_a;
      logic [cti_pkg::IDX_W-1:0] vertex_b;
      logic [cti_pkg::IDX_W-1:0] vertex_c;
      logic [cti_pkg::IDX_W-1:0] vertex_d;
      logic                      out_of_range;
      logic                      last_tet;
   } tetra_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start = 1'b0;
   logic                          busy;
   logic [cti_pkg::IDX_W-1:0]     req_cube_index = '0;
   logic                          rsp_strobe;
   logic [cti_pkg::TET_W-1:0]     rsp_tet_number;
   logic [cti_pkg::IDX_W-1:0]     rsp_vertex_a;
   logic [cti_pkg::IDX_W-1:0]     rsp_vertex_b;
   logic [cti_pkg::IDX_W-1:0]     rsp_vertex_c;
   logic [cti_pkg::IDX_W-1:0]     rsp_vertex_d;
   logic                          rsp_out_of_range;
   logic                          rsp_last_tet;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [cti_pkg::CSR_IDX_W-1:0] csr_index;
   logic [cti_pkg::CELL_W-1:0]    csr_data;

   logic [cti_pkg::CELL_W-1:0] cells_x = cti_pkg::CELLS_RESET;
   logic [cti_pkg::CELL_W-1:0] cells_y = cti_pkg::CELLS_RESET;
   logic [cti_pkg::CELL_W-1:0] cells_z = cti_pkg::CELLS_RESET;

   logic [cti_pkg::IDX_W-1:0] cube_queue [$];
   tetra_type                 tet_expect [$];
   int                        idle_pct = 0;
   int                        accepted = 0;
   int                        checked = 0;
   int                        errors = 0;
   int                        cycles = 0;
   bit                        drain_hold = 1'b0;

   cube_to_tetrahedra_indexer_unit uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cube_index  (req_cube_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_tet_number  (rsp_tet_number),
      .rsp_vertex_a    (rsp_vertex_a),
      .rsp_vertex_b    (rsp_vertex_b),
      .rsp_vertex_c    (rsp_vertex_c),
      .rsp_vertex_d    (rsp_vertex_d),
      .rsp_out_of_range(rsp_out_of_range),
      .rsp_last_tet    (rsp_last_tet),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void push_tetrahedra(logic [cti_pkg::IDX_W-1:0] idx);
      tetra_type                 r;
      int unsigned               sx, sy, sz, count, rest, cx, cy, cz, px, py, pz, pidx;
      logic [2:0]                off;
      logic [cti_pkg::IDX_W-1:0] v [4];
      sx    = cells_x;
      sy    = cells_y;
      sz    = cells_z;
      count = sx * sy * sz;
      if (count == 0 || idx >= count) begin
         r              = '0;
         r.out_of_range = 1'b1;
         r.last_tet     = 1'b1;
         tet_expect.push_back(r);
         return;
      end
      cz   = idx % sz;
      rest = idx / sz;
      cy   = rest % sy;
      rest = rest / sy;
      cx   = rest % sx;
      for (int t = 0; t < cti_pkg::NUM_TETS; t++) begin
         for (int k = 0; k < 4; k++) begin
            off = CUBE_CORNER[TET_CORNER[t][k]];
            // mirror the offset along each odd axis
            if (cx[0]) off[2] = ~off[2];
            if (cy[0]) off[1] = ~off[1];
            if (cz[0]) off[0] = ~off[0];
            px   = cx + off[2];
            py   = cy + off[1];
            pz   = cz + off[0];
            pidx = (px * (sy + 1) + py) * (sz + 1) + pz;
            v[k] = pidx[cti_pkg::IDX_W-1:0];
         end
         r.tet_number   = cti_pkg::TET_W'(t);
         r.vertex_a     = v[0];
         r.vertex_b     = v[1];
         r.vertex_c     = v[2];
         r.vertex_d     = v[3];
         r.out_of_range = 1'b0;
         r.last_tet     = (t == cti_pkg::NUM_TETS - 1);
         tet_expect.push_back(r);
      end
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   // driver: hold start until accepted, then pick the next item or idle
   always @(posedge clock) begin
      bit go;
      if (reset) begin
         start          <= 1'b0;
         req_cube_index <= '0;
      end else begin
         if (start && !busy) begin
            push_tetrahedra(req_cube_index);
            cube_queue.delete(0);
            accepted++;
            if (accepted == 200) drain_hold = 1'b1;
         end
         if (drain_hold && tet_expect.size() == 0) drain_hold = 1'b0;
         if (!start || !busy) begin
            go = cube_queue.size() != 0 && !drain_hold && $urandom_range(99) >= idle_pct;
            start <= go;
            if (go) req_cube_index <= cube_queue[0];
         end
      end
   end

   // monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      tetra_type want;
      if (!reset && rsp_strobe) begin
         if (tet_expect.size() == 0) begin
            $error("unexpected result: tet_number %0d", rsp_tet_number);
            errors++;
         end else begin
            want = tet_expect.pop_front();
            check_field("tet_number", want.tet_number, rsp_tet_number);
            check_field("vertex_a", want.vertex_a, rsp_vertex_a);
            check_field("vertex_b", want.vertex_b, rsp_vertex_b);
            check_field("vertex_c", want.vertex_c, rsp_vertex_c);
            check_field("vertex_d", want.vertex_d, rsp_vertex_d);
            check_field("out_of_range", want.out_of_range, rsp_out_of_range);
            check_field("last_tet", want.last_tet, rsp_last_tet);
            checked++;
         end
      end
   end

   task automatic write_reg(logic [cti_pkg::CSR_IDX_W-1:0] idx,
                            logic [cti_pkg::CELL_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         cti_pkg::CSR_CELLS_X: cells_x = cti_pkg::clamp_cells(value);
         cti_pkg::CSR_CELLS_Y: cells_y = cti_pkg::clamp_cells(value);
         cti_pkg::CSR_CELLS_Z: cells_z = cti_pkg::clamp_cells(value);
         default: ;
      endcase
   endtask

   task automatic set_cells(logic [cti_pkg::CELL_W-1:0] x, logic [cti_pkg::CELL_W-1:0] y,
                            logic [cti_pkg::CELL_W-1:0] z);
      write_reg(cti_pkg::CSR_CELLS_X, x);
      write_reg(cti_pkg::CSR_CELLS_Y, y);
      write_reg(cti_pkg::CSR_CELLS_Z, z);
   endtask

   task automatic drain_results();
      while (cube_queue.size() != 0 || start || tet_expect.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned               count;
      logic [cti_pkg::IDX_W-1:0] idx;
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_index = cti_pkg::CSR_CELLS_X;
      csr_data  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: a single cube
      cube_queue = '{24'd0, 24'd1, 24'hFFFFFF};
      drain_results();

      set_cells(8'd255, 8'd255, 8'd255);
      cube_queue = '{24'd0, 24'd1, 24'd255, 24'd65025, 24'd65281, 24'h555555,
                     24'hAAAAAA, 24'd16581374, 24'd16581375, 24'hFFFFFF};
      drain_results();

      set_cells(8'd2, 8'd3, 8'd4);
      cube_queue = '{24'd17, 24'd23, 24'd24};
      drain_results();

      // zero size on one axis: every index is out of range
      set_cells(8'd0, 8'd5, 8'd5);
      write_reg(CSR_SPARE, 8'hA5);
      cube_queue = '{24'd0, 24'd7};
      drain_results();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       set_cells(8'd3, 8'd4, 8'd5);
            1:       set_cells(8'd7, 8'd1, 8'd255);
            2:       set_cells(8'd255, 8'd255, 8'd255);
            default: set_cells(cti_pkg::CELL_W'($urandom_range(255, 1)),
                               cti_pkg::CELL_W'($urandom_range(255, 1)),
                               cti_pkg::CELL_W'($urandom_range(255, 1)));
         endcase
         idle_pct = (ph == 0) ? 11 : (ph == 1) ? 65 : 0;
         count = int'(cells_x) * int'(cells_y) * int'(cells_z);
         for (int i = 0; i < 100; i++) begin
            if (count != 0 && $urandom_range(99) < 85)
               idx = cti_pkg::IDX_W'($urandom_range(count - 1, 0));
            else
               idx = cti_pkg::IDX_W'($urandom_range(24'hFFFFFF, 0));
            cube_queue.push_back(idx);
         end
         drain_results();
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d cube indexes and %0d tetrahedron results over eight grid settings,",
               accepted, checked);
      $display("including a single cube, 255 per axis, a zero axis and out-of-range indexes.");
      if (errors == 0 && tet_expect.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cti_pkg.sv
rtl/cti_div_stage.sv
rtl/cube_to_tetrahedra_indexer_unit.sv
tb/tb_cube_to_tetrahedra_indexer_unit.sv
